### rtl/pick_place_machine_sequencer_defines.svh
// Assertion macros used by the checker file of the pick-and-place sequencer.
`ifndef PICK_PLACE_MACHINE_SEQUENCER_DEFINES_SVH
`define PICK_PLACE_MACHINE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ppms_pkg.sv
// Package with the types, codes and constants of the pick-and-place sequencer.
package ppms_pkg;

	// Machine mode; codes 5 to 7 are never entered.
	typedef enum logic [2:0] {
		MODE_READY   = 3'd0,
		MODE_MOVING  = 3'd1,
		MODE_PICKING = 3'd2,
		MODE_PLACING = 3'd3,
		MODE_HOMING  = 3'd4
	} mode_t;

	// Command codes carried by each item; 6 and 7 act as empty.
	typedef enum logic [2:0] {
		CMD_EMPTY = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_MOVE  = 3'd2,
		CMD_PICK  = 3'd3,
		CMD_PLACE = 3'd4,
		CMD_HOME  = 3'd5
	} cmd_t;

	// Homing sub-sequence.
	typedef enum logic [2:0] {
		HS_INIT = 3'd0,
		HS_Z    = 3'd1,
		HS_X    = 3'd2,
		HS_Y    = 3'd3,
		HS_YAW  = 3'd4,
		HS_DONE = 3'd5
	} hstep_t;

	// Pick/place sub-sequence.
	typedef enum logic [1:0] {
		PP_INIT    = 2'd0,
		PP_DOWN    = 2'd1,
		PP_CONTACT = 2'd2,
		PP_DONE    = 2'd3
	} pstep_t;

	// Jog axis codes.
	localparam logic [1:0] JOG_NONE = 2'd0;
	localparam logic [1:0] JOG_Z    = 2'd1;
	localparam logic [1:0] JOG_X    = 2'd2;
	localparam logic [1:0] JOG_Y    = 2'd3;

	// Axis-zero mask bits.
	localparam logic [3:0] ZERO_X   = 4'b0001;
	localparam logic [3:0] ZERO_Y   = 4'b0010;
	localparam logic [3:0] ZERO_Z   = 4'b0100;
	localparam logic [3:0] ZERO_YAW = 4'b1000;

	// Configuration register indexes and reset values.
	localparam logic REG_PICK_VACUUM   = 1'b0;
	localparam logic REG_PLACE_RELEASE = 1'b1;
	localparam logic [7:0] PICK_VACUUM_RESET   = 8'd90;
	localparam logic [7:0] PLACE_RELEASE_RESET = 8'd100;

	// Sequencer state held between items.
	typedef struct packed {
		mode_t  mode;
		hstep_t hstep;
		pstep_t pstep;
		logic   pump;
		logic   valve;
	} state_t;

	// One input item.
	typedef struct packed {
		logic [2:0] func;
		logic       move_busy;
		logic       limit_x;
		logic       limit_y;
		logic       limit_z;
		logic [7:0] pressure_kpa;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [2:0] mode;
		logic       pump_on;
		logic       valve_on;
		logic       load_targets;
		logic       run_move;
		logic [1:0] jog_axis;
		logic [3:0] zero_mask;
	} result_t;

endpackage

### rtl/ppms_if.sv
// Valid/ready channel interfaces for the command items and the result items.
interface ppms_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic       move_busy;
	logic       limit_x;
	logic       limit_y;
	logic       limit_z;
	logic [7:0] pressure_kpa;

	modport source (output valid, func, move_busy, limit_x, limit_y, limit_z, pressure_kpa,
		input ready);
	modport sink (input valid, func, move_busy, limit_x, limit_y, limit_z, pressure_kpa,
		output ready);
endinterface

interface ppms_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic       pump_on;
	logic       valve_on;
	logic       load_targets;
	logic       run_move;
	logic [1:0] jog_axis;
	logic [3:0] zero_mask;

	modport source (output valid, mode, pump_on, valve_on, load_targets, run_move, jog_axis,
		zero_mask, input ready);
	modport sink (input valid, mode, pump_on, valve_on, load_targets, run_move, jog_axis,
		zero_mask, output ready);
endinterface

### rtl/ppms_step.sv
// Next-state and result logic for one controller tick of the sequencer.
module ppms_step (
	input  ppms_pkg::state_t  cur,
	input  ppms_pkg::item_t   item,
	input  logic [7:0]        pick_limit,
	input  logic [7:0]        place_limit,
	output ppms_pkg::state_t  nxt,
	output ppms_pkg::result_t res
);
	import ppms_pkg::*;

	logic is_pick;

	assign is_pick = (cur.mode == MODE_PICKING);

	// One tick: stop override, then the work of the current mode.
	always_comb begin
		nxt = cur;
		res = '0;
		if (item.func == CMD_STOP) begin
			nxt.mode = MODE_READY;
		end
		case (nxt.mode)
			MODE_READY: begin
				if (item.func == CMD_MOVE) begin
					nxt.mode = MODE_MOVING;
					res.load_targets = 1'b1;
				end else if (item.func == CMD_PICK) begin
					nxt.mode = MODE_PICKING;
					res.load_targets = 1'b1;
				end else if (item.func == CMD_PLACE) begin
					nxt.mode = MODE_PLACING;
					res.load_targets = 1'b1;
				end else if (item.func == CMD_HOME) begin
					nxt.hstep = HS_INIT;
					nxt.mode = MODE_HOMING;
				end
			end
			MODE_MOVING: begin
				res.run_move = 1'b1;
				if (!item.move_busy) begin
					nxt.mode = MODE_READY;
				end
			end
			MODE_PICKING, MODE_PLACING: begin
				case (cur.pstep)
					PP_INIT: begin
						if (is_pick) begin
							nxt.pump = 1'b1;
							nxt.valve = 1'b1;
						end else begin
							nxt.valve = 1'b0;
						end
						nxt.pstep = PP_DOWN;
					end
					PP_DOWN: begin
						res.run_move = 1'b1;
						if (!item.move_busy) begin
							nxt.pstep = PP_CONTACT;
						end
					end
					PP_CONTACT: begin
						if (is_pick) begin
							nxt.valve = 1'b0;
							if (item.pressure_kpa < pick_limit) begin
								nxt.pstep = PP_DONE;
							end
						end else begin
							nxt.valve = 1'b1;
							if (item.pressure_kpa > place_limit) begin
								nxt.pstep = PP_DONE;
								nxt.pump = 1'b0;
								nxt.valve = 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
				// A finished pick or place returns to ready.
				if (nxt.pstep == PP_DONE) begin
					nxt.mode = MODE_READY;
					nxt.pstep = PP_INIT;
				end
			end
			MODE_HOMING: begin
				case (cur.hstep)
					HS_INIT: begin
						nxt.hstep = HS_Z;
					end
					HS_Z: begin
						if (item.limit_z) begin
							res.zero_mask = ZERO_Z;
							nxt.hstep = HS_X;
						end else begin
							res.jog_axis = JOG_Z;
						end
					end
					HS_X: begin
						if (item.limit_x) begin
							res.zero_mask = ZERO_X;
							nxt.hstep = HS_Y;
						end else begin
							res.jog_axis = JOG_X;
						end
					end
					HS_Y: begin
						if (item.limit_y) begin
							res.zero_mask = ZERO_Y;
							nxt.hstep = HS_YAW;
						end else begin
							res.jog_axis = JOG_Y;
						end
					end
					HS_YAW: begin
						res.zero_mask = ZERO_YAW;
						nxt.hstep = HS_DONE;
					end
					default: begin
						nxt.hstep = HS_DONE;
					end
				endcase
				// A finished homing run returns to ready.
				if (nxt.hstep == HS_DONE) begin
					nxt.mode = MODE_READY;
					nxt.hstep = HS_INIT;
				end
			end
			default: begin
			end
		endcase
		res.mode = nxt.mode;
		res.pump_on = nxt.pump;
		res.valve_on = nxt.valve;
	end

endmodule

### rtl/pick_place_machine_sequencer.sv
// Pick-and-place machine sequencer: input register, tick logic and result register.
// The sequencer takes one controller tick per item and returns one result per item,
// carrying the mode, pump and valve levels and the strobes of that tick after the
// update. It accepts one item every clock cycle unless stalled; each item is held
// in the input register, where the tick logic runs against the held state, and
// then waits in the result register until taken. The input side keeps accepting
// while a result waits, as long as the input register is empty or can move on. The
// two pressure limits are written over the APB port at byte addresses 0 and 4; the
// user must write them only while no item is in flight; the block does not check.
module pick_place_machine_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ppms_cmd_if.sink    item_in,
	ppms_res_if.source  result_out
);
	import ppms_pkg::*;

	logic [7:0] pick_limit_q;
	logic [7:0] place_limit_q;
	logic       cfg_write;
	state_t     state_q;
	state_t     state_next;
	item_t      item_s1;
	logic       valid_s1;
	result_t    result_next;
	result_t    result_s2;
	logic       valid_s2;
	logic       advance;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata = {24'd0, (paddr[2] == REG_PLACE_RELEASE) ? place_limit_q : pick_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_limit_q <= PICK_VACUUM_RESET;
			place_limit_q <= PLACE_RELEASE_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_PICK_VACUUM) begin
				pick_limit_q <= pwdata[7:0];
			end else begin
				place_limit_q <= pwdata[7:0];
			end
		end
	end

	// Handshake: the input register moves on when the result register is free.
	assign advance = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1 <= '{func: item_in.func, move_busy: item_in.move_busy,
				limit_x: item_in.limit_x, limit_y: item_in.limit_y,
				limit_z: item_in.limit_z, pressure_kpa: item_in.pressure_kpa};
		end
	end

	// Tick logic.
	ppms_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.pick_limit  (pick_limit_q),
		.place_limit (place_limit_q),
		.nxt         (state_next),
		.res         (result_next)
	);

	// Sequencer state, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_READY, hstep: HS_INIT, pstep: PP_INIT,
				pump: 1'b0, valve: 1'b0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign result_out.valid = valid_s2;
	assign result_out.mode = result_s2.mode;
	assign result_out.pump_on = result_s2.pump_on;
	assign result_out.valve_on = result_s2.valve_on;
	assign result_out.load_targets = result_s2.load_targets;
	assign result_out.run_move = result_s2.run_move;
	assign result_out.jog_axis = result_s2.jog_axis;
	assign result_out.zero_mask = result_s2.zero_mask;

endmodule

### rtl/ppms_checker.sv
// Port-level checker for the pick-and-place sequencer and its bind statement.
`include "pick_place_machine_sequencer_defines.svh"

module ppms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_mode,
	input logic       res_load_targets,
	input logic       res_run_move,
	input logic [1:0] res_jog_axis,
	input logic [3:0] res_zero_mask
);
	import ppms_pkg::*;

	logic res_take;

	assign res_take = res_valid && res_ready;

	// A result that is not taken stays offered.
	`PPMS_ASSERT_NEXT(a_res_held, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// A target load only starts a move, pick or place and never runs the move itself.
	`PPMS_ASSERT_SAME(a_load_mode, clk, arst_n, res_take && res_load_targets, !res_run_move && (res_mode == MODE_MOVING || res_mode == MODE_PICKING || res_mode == MODE_PLACING), "target load outside a new command")

	// Jogging happens only while homing, and never together with zeroing.
	`PPMS_ASSERT_SAME(a_jog_homing, clk, arst_n, res_take && res_jog_axis != JOG_NONE, res_mode == MODE_HOMING && res_zero_mask == 4'd0, "jog outside homing")

	// At most one axis is zeroed per tick.
	`PPMS_ASSERT_SAME(a_zero_one, clk, arst_n, res_take, $onehot0(res_zero_mask), "several axes zeroed at once")

	// Zeroing and moving never share a tick.
	`PPMS_ASSERT_SAME(a_zero_run, clk, arst_n, res_take && res_zero_mask != 4'd0, !res_run_move && !res_load_targets, "zeroing during a move")

endmodule

bind pick_place_machine_sequencer ppms_checker u_ppms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result_out.valid),
	.res_ready        (result_out.ready),
	.res_mode         (result_out.mode),
	.res_load_targets (result_out.load_targets),
	.res_run_move     (result_out.run_move),
	.res_jog_axis     (result_out.jog_axis),
	.res_zero_mask    (result_out.zero_mask)
);
